/* design/aho_corasick_match_distance_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Aho-Corasick distance matcher
// Concurrent checks clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef AHO_CORASICK_MATCH_DISTANCE_MACROS_SVH
`define AHO_CORASICK_MATCH_DISTANCE_MACROS_SVH

// Same-cycle implication
`define ACMD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("acmd port check failed");

// Next-cycle implication
`define ACMD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("acmd port check failed");

`endif

/* design/acmd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmd_pkg
// Sizes, action and status codes, micro-op codes and the control/status
// structs shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package acmd_pkg;

    localparam int MAX_NODES     = 1024;
    localparam int ALPHABET_SIZE = 26;
    localparam int STACK_DEPTH   = 1024;

    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int CNT_W      = $clog2(MAX_NODES + 1);
    localparam int EDGE_W     = CNT_W;
    localparam int CW         = $clog2(ALPHABET_SIZE);
    localparam int GOTO_DEPTH = MAX_NODES * ALPHABET_SIZE;
    localparam int GADDR_W    = $clog2(GOTO_DEPTH);
    localparam int STK_IW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W       = $clog2(STACK_DEPTH + 1);

    localparam int ACTION_W  = 3;
    localparam int LETTER_W  = 5;
    localparam int DIST_W    = 11;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    // Actions
    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PAT_LETTER = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_END_PAT    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_BUILD      = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TXT_START  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_TXT_LETTER = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_BACKSPACE  = 3'd6;

    // Result status
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NODE_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ORDER      = 2'd3;

    typedef logic [5:0] op_t;

    // Datapath micro-ops
    localparam op_t OP_NONE      = 6'd0;
    localparam op_t OP_LOAD      = 6'd1;
    localparam op_t OP_CLEAR     = 6'd2;
    localparam op_t OP_INIT_WR   = 6'd3;
    localparam op_t OP_PAT_RD    = 6'd4;
    localparam op_t OP_PAT_NEW   = 6'd5;
    localparam op_t OP_PAT_MOVE  = 6'd6;
    localparam op_t OP_END_PAT   = 6'd7;
    localparam op_t OP_TXT_START = 6'd8;
    localparam op_t OP_TXT_PUSH  = 6'd9;
    localparam op_t OP_TXT_MOVE  = 6'd10;
    localparam op_t OP_BS_ROOT   = 6'd11;
    localparam op_t OP_BS_POP    = 6'd12;
    localparam op_t OP_BS_MOVE   = 6'd13;
    localparam op_t OP_EMIT_DIST = 6'd14;
    localparam op_t OP_EMIT_ERR  = 6'd15;
    localparam op_t OP_B_INIT    = 6'd16;
    localparam op_t OP_B_R_RD    = 6'd17;
    localparam op_t OP_B_R_WR    = 6'd18;
    localparam op_t OP_B_Q_POP   = 6'd19;
    localparam op_t OP_B_Q_U     = 6'd20;
    localparam op_t OP_B_Q_F     = 6'd21;
    localparam op_t OP_B_Q_E     = 6'd22;
    localparam op_t OP_B_C_RD    = 6'd23;
    localparam op_t OP_B_C_WR    = 6'd24;
    localparam op_t OP_D_INIT    = 6'd25;
    localparam op_t OP_D_I_RD    = 6'd26;
    localparam op_t OP_D_I_WR    = 6'd27;
    localparam op_t OP_D_S_START = 6'd28;
    localparam op_t OP_D_U_RD    = 6'd29;
    localparam op_t OP_D_C_RD    = 6'd30;
    localparam op_t OP_D_C_DR    = 6'd31;
    localparam op_t OP_D_C_MIN   = 6'd32;
    localparam op_t OP_D_U_UPD   = 6'd33;
    localparam op_t OP_B_DONE    = 6'd34;

    typedef struct packed {
        op_t                 op;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                has_root;
        logic                built;
        logic                letter_ok;
        logic                node_full;
        logic                stack_full;
        logic                sc_zero;
        logic                rd_no_edge;
        logic                c_last;
        logic                u_last;
        logic                head_eq_tail;
        logic                changed;
        logic                out_free;
    } stat_t;

endpackage

/* design/acmd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmd_ctrl
// Sequencer: decodes each accepted beat, runs trie loading, the fail-link
// and distance build passes and text steps as a series of datapath micro-ops.
// ----------------------------------------------------------------------------
module acmd_ctrl
    import acmd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DECODE    = 5'd1;
    localparam logic [4:0] S_INIT      = 5'd2;
    localparam logic [4:0] S_PAT_CHK   = 5'd3;
    localparam logic [4:0] S_TXT_GO    = 5'd4;
    localparam logic [4:0] S_BS_GO     = 5'd5;
    localparam logic [4:0] S_EMIT_DIST = 5'd6;
    localparam logic [4:0] S_EMIT_ERR  = 5'd7;
    localparam logic [4:0] S_B_R_RD    = 5'd8;
    localparam logic [4:0] S_B_R_WR    = 5'd9;
    localparam logic [4:0] S_B_Q_CHK   = 5'd10;
    localparam logic [4:0] S_B_Q_U     = 5'd11;
    localparam logic [4:0] S_B_Q_F     = 5'd12;
    localparam logic [4:0] S_B_Q_E     = 5'd13;
    localparam logic [4:0] S_B_C_RD    = 5'd14;
    localparam logic [4:0] S_B_C_WR    = 5'd15;
    localparam logic [4:0] S_D_I_RD    = 5'd16;
    localparam logic [4:0] S_D_I_WR    = 5'd17;
    localparam logic [4:0] S_D_S_START = 5'd18;
    localparam logic [4:0] S_D_U_RD    = 5'd19;
    localparam logic [4:0] S_D_C_RD    = 5'd20;
    localparam logic [4:0] S_D_C_DR    = 5'd21;
    localparam logic [4:0] S_D_C_MIN   = 5'd22;
    localparam logic [4:0] S_D_U_UPD   = 5'd23;
    localparam logic [4:0] S_D_S_END   = 5'd24;

    logic [4:0]          state_reg, state_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic                load_ok;

    // Loading actions need a root and an unbuilt automaton
    assign load_ok = stat.has_root && !stat.built;

    // Next state and micro-op
    always_comb begin
        state_next = state_reg;
        err_next   = err_reg;
        cmd.op     = OP_NONE;
        cmd.status = err_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                err_next   = ST_ORDER;
                state_next = S_EMIT_ERR;
                case (stat.action)
                    ACT_CLEAR: begin
                        cmd.op     = OP_CLEAR;
                        state_next = S_INIT;
                    end
                    ACT_PAT_LETTER: begin
                        if (load_ok && stat.letter_ok) begin
                            cmd.op     = OP_PAT_RD;
                            state_next = S_PAT_CHK;
                        end
                    end
                    ACT_END_PAT: begin
                        if (load_ok) begin
                            cmd.op     = OP_END_PAT;
                            state_next = S_IDLE;
                        end
                    end
                    ACT_BUILD: begin
                        if (load_ok) begin
                            cmd.op     = OP_B_INIT;
                            state_next = S_B_R_RD;
                        end
                    end
                    ACT_TXT_START: begin
                        if (stat.built) begin
                            cmd.op     = OP_TXT_START;
                            state_next = S_EMIT_DIST;
                        end
                    end
                    ACT_TXT_LETTER: begin
                        if (stat.built && stat.letter_ok) begin
                            if (stat.stack_full) begin
                                err_next = ST_STACK_FULL;
                            end else begin
                                cmd.op     = OP_TXT_PUSH;
                                state_next = S_TXT_GO;
                            end
                        end
                    end
                    ACT_BACKSPACE: begin
                        if (stat.built) begin
                            if (stat.sc_zero) begin
                                cmd.op     = OP_BS_ROOT;
                                state_next = S_EMIT_DIST;
                            end else begin
                                cmd.op     = OP_BS_POP;
                                state_next = S_BS_GO;
                            end
                        end
                    end
                    default: begin
                        state_next = S_EMIT_ERR;
                    end
                endcase
            end
            S_INIT: begin
                cmd.op = OP_INIT_WR;
                if (stat.c_last) state_next = S_IDLE;
            end
            S_PAT_CHK: begin
                if (stat.rd_no_edge) begin
                    if (stat.node_full) begin
                        err_next   = ST_NODE_FULL;
                        state_next = S_EMIT_ERR;
                    end else begin
                        cmd.op     = OP_PAT_NEW;
                        state_next = S_INIT;
                    end
                end else begin
                    cmd.op     = OP_PAT_MOVE;
                    state_next = S_IDLE;
                end
            end
            S_TXT_GO: begin
                cmd.op     = OP_TXT_MOVE;
                state_next = S_EMIT_DIST;
            end
            S_BS_GO: begin
                cmd.op     = OP_BS_MOVE;
                state_next = S_EMIT_DIST;
            end
            S_EMIT_DIST: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT_DIST;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_ERR: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT_ERR;
                    state_next = S_IDLE;
                end
            end
            S_B_R_RD: begin
                cmd.op     = OP_B_R_RD;
                state_next = S_B_R_WR;
            end
            S_B_R_WR: begin
                cmd.op     = OP_B_R_WR;
                state_next = stat.c_last ? S_B_Q_CHK : S_B_R_RD;
            end
            S_B_Q_CHK: begin
                if (stat.head_eq_tail) begin
                    cmd.op     = OP_D_INIT;
                    state_next = S_D_I_RD;
                end else begin
                    cmd.op     = OP_B_Q_POP;
                    state_next = S_B_Q_U;
                end
            end
            S_B_Q_U: begin
                cmd.op     = OP_B_Q_U;
                state_next = S_B_Q_F;
            end
            S_B_Q_F: begin
                cmd.op     = OP_B_Q_F;
                state_next = S_B_Q_E;
            end
            S_B_Q_E: begin
                cmd.op     = OP_B_Q_E;
                state_next = S_B_C_RD;
            end
            S_B_C_RD: begin
                cmd.op     = OP_B_C_RD;
                state_next = S_B_C_WR;
            end
            S_B_C_WR: begin
                cmd.op     = OP_B_C_WR;
                state_next = stat.c_last ? S_B_Q_CHK : S_B_C_RD;
            end
            S_D_I_RD: begin
                cmd.op     = OP_D_I_RD;
                state_next = S_D_I_WR;
            end
            S_D_I_WR: begin
                cmd.op     = OP_D_I_WR;
                state_next = stat.u_last ? S_D_S_START : S_D_I_RD;
            end
            S_D_S_START: begin
                cmd.op     = OP_D_S_START;
                state_next = S_D_U_RD;
            end
            S_D_U_RD: begin
                cmd.op     = OP_D_U_RD;
                state_next = S_D_C_RD;
            end
            S_D_C_RD: begin
                cmd.op     = OP_D_C_RD;
                state_next = S_D_C_DR;
            end
            S_D_C_DR: begin
                cmd.op     = OP_D_C_DR;
                state_next = S_D_C_MIN;
            end
            S_D_C_MIN: begin
                cmd.op     = OP_D_C_MIN;
                state_next = stat.c_last ? S_D_U_UPD : S_D_C_RD;
            end
            S_D_U_UPD: begin
                cmd.op     = OP_D_U_UPD;
                state_next = stat.u_last ? S_D_S_END : S_D_U_RD;
            end
            S_D_S_END: begin
                if (stat.changed) begin
                    state_next = S_D_S_START;
                end else begin
                    cmd.op     = OP_B_DONE;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            err_reg   <= ST_OK;
        end else begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

endmodule

/* design/acmd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmd_datapath
// Goto, fail, end-mark, distance, queue and text stack memories, the
// automaton counters and the result register, driven by micro-ops.
// ----------------------------------------------------------------------------
module acmd_datapath
    import acmd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic [ACTION_W-1:0]   in_action,
    input  logic [LETTER_W-1:0]   in_letter,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [DIST_W-1:0]     out_distance,
    output logic [STATUS_W-1:0]   out_status
);

    localparam logic [EDGE_W-1:0] NO_EDGE = EDGE_W'(MAX_NODES);
    localparam logic [DIST_W-1:0] INF     = {DIST_W{1'b1}};

    function automatic logic [GADDR_W-1:0] gaddr(input logic [NODE_W-1:0] n,
                                                 input logic [CW-1:0] c);
        return GADDR_W'(n) * GADDR_W'(ALPHABET_SIZE) + GADDR_W'(c);
    endfunction

    // Memories
    logic [EDGE_W-1:0] goto_mem [GOTO_DEPTH];
    logic [NODE_W-1:0] fail_mem [MAX_NODES];
    logic              end_mem  [MAX_NODES];
    logic [DIST_W-1:0] dist_mem [MAX_NODES];
    logic [NODE_W-1:0] q_mem    [MAX_NODES];
    logic [NODE_W-1:0] stk_mem  [STACK_DEPTH];

    logic               g_we, g_rea, g_reb;
    logic [GADDR_W-1:0] g_waddr, g_raddra, g_raddrb;
    logic [EDGE_W-1:0]  g_wdata, g_rda_reg, g_rdb_reg;
    logic               f_we, f_re;
    logic [NODE_W-1:0]  f_waddr, f_raddr, f_wdata, f_rd_reg;
    logic               e_we, e_re, e_wdata, e_rd_reg;
    logic [NODE_W-1:0]  e_waddr, e_raddr;
    logic               d_we, d_rea, d_reb;
    logic [NODE_W-1:0]  d_waddr, d_raddra, d_raddrb;
    logic [DIST_W-1:0]  d_wdata, d_rda_reg, d_rdb_reg;
    logic               q_we, q_re;
    logic [NODE_W-1:0]  q_waddr, q_raddr, q_wdata, q_rd_reg;
    logic               stk_we, stk_re;
    logic [STK_IW-1:0]  stk_waddr, stk_raddr;
    logic [NODE_W-1:0]  stk_wdata, stk_rd_reg;

    // Automaton and sequencing registers
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [LETTER_W-1:0] let_reg, let_next;
    logic [CNT_W-1:0]    nc_reg, nc_next;
    logic [NODE_W-1:0]   cursor_reg, cursor_next;
    logic [NODE_W-1:0]   cur_reg, cur_next;
    logic [SP_W-1:0]     sc_reg, sc_next;
    logic                built_reg, built_next;
    logic [NODE_W-1:0]   row_reg, row_next;
    logic [CW-1:0]       c_reg, c_next;
    logic [CNT_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    tail_reg, tail_next;
    logic [NODE_W-1:0]   u_reg, u_next;
    logic [NODE_W-1:0]   f_reg, f_next;
    logic [DIST_W-1:0]   min_reg, min_next;
    logic                changed_reg, changed_next;
    logic                out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]   out_dist_reg, out_dist_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic [NODE_W-1:0] rd_node;
    logic              c_last;
    logic [CW-1:0]     c_step;
    logic [CW-1:0]     let_c;
    logic [DIST_W-1:0] cand;
    logic [SP_W-1:0]   sc_dec;
    logic              out_free;

    assign rd_node  = g_rda_reg[NODE_W-1:0];
    assign c_last   = (c_reg == CW'(ALPHABET_SIZE - 1));
    assign c_step   = c_last ? '0 : c_reg + CW'(1);
    assign let_c    = CW'(let_reg);
    assign cand     = (min_reg == INF) ? INF : min_reg + DIST_W'(1);
    assign sc_dec   = sc_reg - SP_W'(1);
    assign out_free = !out_valid_reg || out_ready;

    // Status to the sequencer
    always_comb begin
        stat.action       = act_reg;
        stat.has_root     = (nc_reg != '0);
        stat.built        = built_reg;
        stat.letter_ok    = (LETTER_W'(let_reg) < LETTER_W'(ALPHABET_SIZE));
        stat.node_full    = (nc_reg >= CNT_W'(MAX_NODES));
        stat.stack_full   = (sc_reg >= SP_W'(STACK_DEPTH));
        stat.sc_zero      = (sc_reg == '0);
        stat.rd_no_edge   = (g_rda_reg == NO_EDGE);
        stat.c_last       = c_last;
        stat.u_last       = ((CNT_W'(u_reg) + CNT_W'(1)) == nc_reg);
        stat.head_eq_tail = (head_reg == tail_reg);
        stat.changed      = changed_reg;
        stat.out_free     = out_free;
    end

    // Micro-op decode: register updates and memory port controls
    always_comb begin
        act_next        = act_reg;
        let_next        = let_reg;
        nc_next         = nc_reg;
        cursor_next     = cursor_reg;
        cur_next        = cur_reg;
        sc_next         = sc_reg;
        built_next      = built_reg;
        row_next        = row_reg;
        c_next          = c_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        u_next          = u_reg;
        f_next          = f_reg;
        min_next        = min_reg;
        changed_next    = changed_reg;
        out_dist_next   = out_dist_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        g_we = 1'b0; g_waddr = '0; g_wdata = '0;
        g_rea = 1'b0; g_raddra = '0; g_reb = 1'b0; g_raddrb = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_re = 1'b0; f_raddr = '0;
        e_we = 1'b0; e_waddr = '0; e_wdata = 1'b0; e_re = 1'b0; e_raddr = '0;
        d_we = 1'b0; d_waddr = '0; d_wdata = '0;
        d_rea = 1'b0; d_raddra = '0; d_reb = 1'b0; d_raddrb = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_re = 1'b0; q_raddr = '0;
        stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0; stk_re = 1'b0; stk_raddr = '0;

        case (cmd.op)
            OP_LOAD: begin
                act_next = in_action;
                let_next = in_letter;
            end
            OP_CLEAR: begin
                cursor_next = '0;
                cur_next    = '0;
                sc_next     = '0;
                built_next  = 1'b0;
                row_next    = '0;
                c_next      = '0;
            end
            OP_INIT_WR: begin
                // Fill one row of a fresh node with missing edges
                g_we    = 1'b1;
                g_waddr = gaddr(row_reg, c_reg);
                g_wdata = NO_EDGE;
                if (c_reg == '0) begin
                    e_we    = 1'b1;
                    e_waddr = row_reg;
                    e_wdata = 1'b0;
                end
                c_next = c_step;
                if (c_last) nc_next = CNT_W'(row_reg) + CNT_W'(1);
            end
            OP_PAT_RD: begin
                g_rea    = 1'b1;
                g_raddra = gaddr(cursor_reg, let_c);
            end
            OP_PAT_NEW: begin
                g_we        = 1'b1;
                g_waddr     = gaddr(cursor_reg, let_c);
                g_wdata     = EDGE_W'(nc_reg);
                cursor_next = nc_reg[NODE_W-1:0];
                row_next    = nc_reg[NODE_W-1:0];
                c_next      = '0;
            end
            OP_PAT_MOVE: begin
                cursor_next = rd_node;
            end
            OP_END_PAT: begin
                e_we        = 1'b1;
                e_waddr     = cursor_reg;
                e_wdata     = 1'b1;
                cursor_next = '0;
            end
            OP_TXT_START: begin
                cur_next = '0;
                sc_next  = '0;
                d_rea    = 1'b1;
                d_raddra = '0;
            end
            OP_TXT_PUSH: begin
                stk_we    = 1'b1;
                stk_waddr = sc_reg[STK_IW-1:0];
                stk_wdata = cur_reg;
                sc_next   = sc_reg + SP_W'(1);
                g_rea     = 1'b1;
                g_raddra  = gaddr(cur_reg, let_c);
            end
            OP_TXT_MOVE: begin
                cur_next = rd_node;
                d_rea    = 1'b1;
                d_raddra = rd_node;
            end
            OP_BS_ROOT: begin
                cur_next = '0;
                d_rea    = 1'b1;
                d_raddra = '0;
            end
            OP_BS_POP: begin
                sc_next   = sc_dec;
                stk_re    = 1'b1;
                stk_raddr = sc_dec[STK_IW-1:0];
            end
            OP_BS_MOVE: begin
                cur_next = stk_rd_reg;
                d_rea    = 1'b1;
                d_raddra = stk_rd_reg;
            end
            OP_EMIT_DIST: begin
                out_valid_next  = 1'b1;
                out_dist_next   = d_rda_reg;
                out_status_next = ST_OK;
            end
            OP_EMIT_ERR: begin
                out_valid_next  = 1'b1;
                out_dist_next   = INF;
                out_status_next = cmd.status;
            end
            OP_B_INIT: begin
                f_we      = 1'b1;
                f_waddr   = '0;
                f_wdata   = '0;
                c_next    = '0;
                head_next = '0;
                tail_next = '0;
            end
            OP_B_R_RD: begin
                g_rea    = 1'b1;
                g_raddra = gaddr('0, c_reg);
            end
            OP_B_R_WR: begin
                // Root edges: missing ones loop back, real ones seed the queue
                if (g_rda_reg == NO_EDGE) begin
                    g_we    = 1'b1;
                    g_waddr = gaddr('0, c_reg);
                    g_wdata = '0;
                end else begin
                    f_we      = 1'b1;
                    f_waddr   = rd_node;
                    f_wdata   = '0;
                    q_we      = 1'b1;
                    q_waddr   = tail_reg[NODE_W-1:0];
                    q_wdata   = rd_node;
                    tail_next = tail_reg + CNT_W'(1);
                end
                c_next = c_step;
            end
            OP_B_Q_POP: begin
                q_re      = 1'b1;
                q_raddr   = head_reg[NODE_W-1:0];
                head_next = head_reg + CNT_W'(1);
            end
            OP_B_Q_U: begin
                u_next  = q_rd_reg;
                f_re    = 1'b1;
                f_raddr = q_rd_reg;
            end
            OP_B_Q_F: begin
                f_next  = f_rd_reg;
                e_re    = 1'b1;
                e_raddr = f_rd_reg;
                c_next  = '0;
            end
            OP_B_Q_E: begin
                // Inherit the pattern end of the fail target
                if (e_rd_reg) begin
                    e_we    = 1'b1;
                    e_waddr = u_reg;
                    e_wdata = 1'b1;
                end
            end
            OP_B_C_RD: begin
                g_rea    = 1'b1;
                g_raddra = gaddr(u_reg, c_reg);
                g_reb    = 1'b1;
                g_raddrb = gaddr(f_reg, c_reg);
            end
            OP_B_C_WR: begin
                if (g_rda_reg == NO_EDGE) begin
                    g_we    = 1'b1;
                    g_waddr = gaddr(u_reg, c_reg);
                    g_wdata = g_rdb_reg;
                end else begin
                    f_we      = 1'b1;
                    f_waddr   = rd_node;
                    f_wdata   = g_rdb_reg[NODE_W-1:0];
                    q_we      = 1'b1;
                    q_waddr   = tail_reg[NODE_W-1:0];
                    q_wdata   = rd_node;
                    tail_next = tail_reg + CNT_W'(1);
                end
                c_next = c_step;
            end
            OP_D_INIT: begin
                u_next = '0;
            end
            OP_D_I_RD: begin
                e_re    = 1'b1;
                e_raddr = u_reg;
            end
            OP_D_I_WR: begin
                d_we    = 1'b1;
                d_waddr = u_reg;
                d_wdata = e_rd_reg ? '0 : INF;
                u_next  = u_reg + NODE_W'(1);
            end
            OP_D_S_START: begin
                u_next       = '0;
                changed_next = 1'b0;
            end
            OP_D_U_RD: begin
                d_reb    = 1'b1;
                d_raddrb = u_reg;
                min_next = INF;
                c_next   = '0;
            end
            OP_D_C_RD: begin
                g_rea    = 1'b1;
                g_raddra = gaddr(u_reg, c_reg);
            end
            OP_D_C_DR: begin
                d_rea    = 1'b1;
                d_raddra = rd_node;
            end
            OP_D_C_MIN: begin
                if (d_rda_reg < min_reg) min_next = d_rda_reg;
                c_next = c_step;
            end
            OP_D_U_UPD: begin
                // Relax: one step more than the best successor
                if (cand < d_rdb_reg) begin
                    d_we         = 1'b1;
                    d_waddr      = u_reg;
                    d_wdata      = cand;
                    changed_next = 1'b1;
                end
                u_next = u_reg + NODE_W'(1);
            end
            OP_B_DONE: begin
                built_next = 1'b1;
                cur_next   = '0;
                sc_next    = '0;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nc_reg        <= '0;
            cursor_reg    <= '0;
            cur_reg       <= '0;
            sc_reg        <= '0;
            built_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            nc_reg        <= nc_next;
            cursor_reg    <= cursor_next;
            cur_reg       <= cur_next;
            sc_reg        <= sc_next;
            built_reg     <= built_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        let_reg        <= let_next;
        row_reg        <= row_next;
        c_reg          <= c_next;
        head_reg       <= head_next;
        tail_reg       <= tail_next;
        u_reg          <= u_next;
        f_reg          <= f_next;
        min_reg        <= min_next;
        changed_reg    <= changed_next;
        out_dist_reg   <= out_dist_next;
        out_status_reg <= out_status_next;
    end

    // Goto table: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (g_we)  goto_mem[g_waddr] <= g_wdata;
        if (g_rea) g_rda_reg <= goto_mem[g_raddra];
        if (g_reb) g_rdb_reg <= goto_mem[g_raddrb];
    end

    // Fail links
    always_ff @(posedge aclk) begin
        if (f_we) fail_mem[f_waddr] <= f_wdata;
        if (f_re) f_rd_reg <= fail_mem[f_raddr];
    end

    // End marks
    always_ff @(posedge aclk) begin
        if (e_we) end_mem[e_waddr] <= e_wdata;
        if (e_re) e_rd_reg <= end_mem[e_raddr];
    end

    // Node distances: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (d_we)  dist_mem[d_waddr] <= d_wdata;
        if (d_rea) d_rda_reg <= dist_mem[d_raddra];
        if (d_reb) d_rdb_reg <= dist_mem[d_raddrb];
    end

    // Breadth-first queue
    always_ff @(posedge aclk) begin
        if (q_we) q_mem[q_waddr] <= q_wdata;
        if (q_re) q_rd_reg <= q_mem[q_raddr];
    end

    // Text state stack
    always_ff @(posedge aclk) begin
        if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
        if (stk_re) stk_rd_reg <= stk_mem[stk_raddr];
    end

    assign out_valid    = out_valid_reg;
    assign out_distance = out_dist_reg;
    assign out_status   = out_status_reg;

endmodule

/* design/aho_corasick_match_distance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aho_corasick_match_distance
// Aho-Corasick automaton reporting distance to the nearest pattern end.
// ----------------------------------------------------------------------------
// Usage:
//  s_ beats carry an action and a letter; m_ beats carry a signed distance
//  and a status. Clear gives no result beat, nor do pattern letter, end
//  pattern and build beats once accepted; every other beat gives exactly one.
//  One beat is worked at a time. A text letter loads the result register
//  after a goto read, then a distance read, and the next beat is taken
//  after that; start text and empty-stack backspace load it after a
//  distance read alone, backspace with a stored state after a stack read
//  and a distance read. A pattern letter does a goto read, plus a row fill
//  at one goto write per cycle when it creates a node; clear fills the root row.
//  Build: a pass over the root row, fail links for each queued node, a
//  pass seeding node distances, then relaxation sweeps of 26
//  goto-then-distance reads per node until a sweep changes nothing.
//  Reset empties the automaton; no clearing pass runs. A stalled receiver
//  holds the result register; the next beat is still accepted and worked
//  up to its own result, which then waits for the register to drain.
// ----------------------------------------------------------------------------
module aho_corasick_match_distance
    import acmd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [2:0] action, [7:3] letter
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [10:0] distance, [12:11] status
);

    cmd_t                cmd;
    stat_t               stat;
    logic [DIST_W-1:0]   distance;
    logic [STATUS_W-1:0] status;

    acmd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    acmd_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .in_action    (s_tdata[ACTION_W-1:0]),
        .in_letter    (s_tdata[ACTION_W+LETTER_W-1:ACTION_W]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_distance (distance),
        .out_status   (status)
    );

    // Pack the result beat
    assign m_tdata = {{(M_TDATA_W - DIST_W - STATUS_W){1'b0}}, status, distance};

endmodule

/* design/acmd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmd_checker
// Port-level checks on the distance matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "aho_corasick_match_distance_macros.svh"

module acmd_checker
    import acmd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [DIST_W-1:0]   m_dist;
    logic [STATUS_W-1:0] m_status;
    logic                unused_in;

    // Split the result beat into its fields
    assign m_dist    = m_tdata[DIST_W-1:0];
    assign m_status  = m_tdata[DIST_W+STATUS_W-1:DIST_W];
    assign unused_in = ^s_tdata;

    // Refused beats always report an unreachable distance
    `ACMD_ASSERT_IMP(a_err_dist, m_tvalid && (m_status != ST_OK), m_dist == {DIST_W{1'b1}})

    // Good results are -1 or non-negative below the node limit
    `ACMD_ASSERT_IMP(a_ok_dist, m_tvalid && (m_status == ST_OK), !m_dist[DIST_W-1] || &m_dist)

    // One beat in flight: ready drops after an accept
    `ACMD_ASSERT_NXT(a_one_beat, s_tvalid && s_tready, !s_tready)

    // A stalled result holds
    `ACMD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind aho_corasick_match_distance acmd_checker u_acmd_checker (.*);
